// ----- src/lteb_pkg.sv -----
// Shared constants for the lidar time-to-collision emergency brake.
// Holds register indexes, reset values and fixed-point sine coefficients.
// No dependencies.
package lteb_pkg;

    localparam int TRIG_TABLE_DEPTH = 1024;
    localparam int TRIG_IDX_W       = $clog2(TRIG_TABLE_DEPTH);
    localparam int TRIG_DROP        = 16 - TRIG_IDX_W;
    localparam logic [15:0] ANGLE_QMASK = 16'(16'hFFFF << TRIG_DROP);

    localparam logic [1:0] REG_ANGLE_START   = 2'd0;
    localparam logic [1:0] REG_ANGLE_STEP    = 2'd1;
    localparam logic [1:0] REG_RANGE_LIMIT   = 2'd2;
    localparam logic [1:0] REG_TTC_THRESHOLD = 2'd3;

    localparam logic [15:0] ANGLE_START_RST   = 16'd0;
    localparam logic [15:0] ANGLE_STEP_RST    = 16'd0;
    localparam logic [15:0] RANGE_LIMIT_RST   = 16'd30000;
    localparam logic [15:0] TTC_THRESHOLD_RST = 16'd500;

    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic [14:0] QUARTER_FRAC = 15'd16384;

    localparam logic [15:0] SIN_A       = 16'd51472;
    localparam logic [14:0] SIN_B       = 15'd21024;
    localparam logic [11:0] SIN_C       = 12'd2320;
    localparam logic [9:0]  RANGE_SCALE = 10'd1000;

endpackage

// ----- src/lidar_ttc_emergency_brake_core.sv -----
// Top level of the lidar time-to-collision emergency brake.
// Uses lteb_pkg; one shared 18x18 signed multiplier under a sequencer.
// s_ready is high only in the idle state, so the core takes no new beam until it is done
// with the last one; an invalid or out-of-range beam skips the arithmetic. A usable beam makes
// 13 passes through the single multiplier (two sine polynomials, projection, TTC test).
// The brake result is registered when the last beam of a scan is done; the sequencer holds
// it back while a previous result is stalled. Reset (aresetn low, synchronous) clears the
// sequencer, scan state, hit flag, output valid and restores configuration defaults.
module lidar_ttc_emergency_brake_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_range_mm,
    input  logic        s_range_valid,
    input  logic signed [15:0] s_vel_x_mm_s,
    input  logic signed [15:0] s_vel_y_mm_s,
    input  logic        s_last_beam,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_brake
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_T    = 4'd2;
    localparam logic [3:0] ST_U    = 4'd3;
    localparam logic [3:0] ST_S    = 4'd4;
    localparam logic [3:0] ST_R    = 4'd5;
    localparam logic [3:0] ST_MX   = 4'd6;
    localparam logic [3:0] ST_MY   = 4'd7;
    localparam logic [3:0] ST_MS   = 4'd8;
    localparam logic [3:0] ST_ML   = 4'd9;
    localparam logic [3:0] ST_MH   = 4'd10;
    localparam logic [3:0] ST_CMP  = 4'd11;
    localparam logic [3:0] ST_FIN  = 4'd12;

    logic [3:0]  state_reg, state_next;
    logic [15:0] angle_start_reg, angle_start_next;
    logic [15:0] angle_step_reg, angle_step_next;
    logic [15:0] range_limit_reg, range_limit_next;
    logic [15:0] ttc_thr_reg, ttc_thr_next;
    logic [15:0] angle_phase_reg, angle_phase_next;
    logic        scan_started_reg, scan_started_next;
    logic        collision_reg, collision_next;
    logic        hit_reg, hit_next;
    logic        pass_reg, pass_next;
    logic        m_valid_reg, m_valid_next;
    logic        m_brake_reg, m_brake_next;

    logic [15:0] range_reg, range_next;
    logic signed [15:0] vx_reg, vx_next;
    logic signed [15:0] vy_reg, vy_next;
    logic        last_reg, last_next;
    logic [15:0] qangle_reg, qangle_next;
    logic [15:0] ang_reg, ang_next;
    logic [15:0] x2_reg, x2_next;
    logic signed [17:0] cos_reg, cos_next;
    logic signed [17:0] sin_reg, sin_next;
    logic signed [35:0] acc_reg, acc_next;
    logic signed [35:0] speed_reg, speed_next;
    logic [40:0] lhs_reg, lhs_next;
    logic [32:0] rlo_reg, rlo_next;

    logic signed [17:0] op_a, op_b;
    logic signed [35:0] prod_reg, prod_next;

    logic [15:0] cur_phase;
    logic [14:0] xh;
    logic [15:0] xq;
    logic [14:0] sub_b;
    logic [15:0] sub_a;
    logic [15:0] s_mag;
    logic signed [17:0] trig;
    logic [47:0] rhs;
    logic        accept;
    logic        usable;
    logic        out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_brake   = m_brake_reg;

    assign accept    = s_valid && s_ready;
    assign cur_phase = scan_started_reg ? angle_phase_reg : angle_start_reg;
    assign usable    = s_range_valid && (s_range_mm <= range_limit_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // Quarter-wave fold of the current sine argument.
    assign xh    = ang_reg[14] ? 15'(lteb_pkg::QUARTER_FRAC - {1'b0, ang_reg[13:0]})
                               : {1'b0, ang_reg[13:0]};
    assign xq    = {xh, 1'b0};
    assign sub_b = 15'(lteb_pkg::SIN_B - {2'b00, prod_reg[27:15]});
    assign sub_a = 16'(lteb_pkg::SIN_A - {1'b0, prod_reg[29:15]});
    assign s_mag = prod_reg[30:15];
    assign trig  = ang_reg[15] ? -$signed({2'b00, s_mag}) : $signed({2'b00, s_mag});
    assign rhs   = {prod_reg[30:0], 17'b0} + {15'b0, rlo_reg};

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_SQ: begin
                op_a = $signed({2'b00, xq});
                op_b = $signed({2'b00, xq});
            end
            ST_T: begin
                op_a = $signed({2'b00, prod_reg[30:15]});
                op_b = $signed({6'b0, lteb_pkg::SIN_C});
            end
            ST_U: begin
                op_a = $signed({2'b00, x2_reg});
                op_b = $signed({3'b000, sub_b});
            end
            ST_S: begin
                op_a = $signed({2'b00, xq});
                op_b = $signed({2'b00, sub_a});
            end
            ST_MX: begin
                op_a = {{2{vx_reg[15]}}, vx_reg};
                op_b = cos_reg;
            end
            ST_MY: begin
                op_a = {{2{vy_reg[15]}}, vy_reg};
                op_b = sin_reg;
            end
            ST_MS: begin
                op_a = $signed({2'b00, range_reg});
                op_b = $signed({8'b0, lteb_pkg::RANGE_SCALE});
            end
            ST_ML: begin
                op_a = $signed({1'b0, speed_reg[16:0]});
                op_b = $signed({2'b00, ttc_thr_reg});
            end
            ST_MH: begin
                op_a = $signed({3'b000, speed_reg[31:17]});
                op_b = $signed({2'b00, ttc_thr_reg});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    always_comb begin
        state_next        = state_reg;
        angle_start_next  = angle_start_reg;
        angle_step_next   = angle_step_reg;
        range_limit_next  = range_limit_reg;
        ttc_thr_next      = ttc_thr_reg;
        angle_phase_next  = angle_phase_reg;
        scan_started_next = scan_started_reg;
        collision_next    = collision_reg;
        hit_next          = hit_reg;
        pass_next         = pass_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_brake_next      = m_brake_reg;
        range_next        = range_reg;
        vx_next           = vx_reg;
        vy_next           = vy_reg;
        last_next         = last_reg;
        qangle_next       = qangle_reg;
        ang_next          = ang_reg;
        x2_next           = x2_reg;
        cos_next          = cos_reg;
        sin_next          = sin_reg;
        acc_next          = acc_reg;
        speed_next        = speed_reg;
        lhs_next          = lhs_reg;
        rlo_next          = rlo_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lteb_pkg::REG_ANGLE_START:   angle_start_next = cfg_data;
                lteb_pkg::REG_ANGLE_STEP:    angle_step_next  = cfg_data;
                lteb_pkg::REG_RANGE_LIMIT:   range_limit_next = cfg_data;
                lteb_pkg::REG_TTC_THRESHOLD: ttc_thr_next     = cfg_data;
                default:                     angle_start_next = angle_start_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    range_next        = s_range_mm;
                    vx_next           = s_vel_x_mm_s;
                    vy_next           = s_vel_y_mm_s;
                    last_next         = s_last_beam;
                    scan_started_next = 1'b1;
                    angle_phase_next  = 16'(cur_phase + angle_step_reg);
                    qangle_next       = cur_phase & lteb_pkg::ANGLE_QMASK;
                    ang_next          = 16'((cur_phase & lteb_pkg::ANGLE_QMASK)
                                            + lteb_pkg::QUARTER_TURN);
                    hit_next          = 1'b0;
                    pass_next         = 1'b0;
                    state_next        = usable ? ST_SQ : ST_FIN;
                end
            end
            ST_SQ: state_next = ST_T;
            ST_T: begin
                x2_next    = prod_reg[30:15];
                state_next = ST_U;
            end
            ST_U: state_next = ST_S;
            ST_S: state_next = ST_R;
            ST_R: begin
                if (!pass_reg) begin
                    cos_next   = trig;
                    ang_next   = qangle_reg;
                    pass_next  = 1'b1;
                    state_next = ST_SQ;
                end else begin
                    sin_next   = trig;
                    state_next = ST_MX;
                end
            end
            ST_MX: state_next = ST_MY;
            ST_MY: begin
                acc_next   = prod_reg;
                state_next = ST_MS;
            end
            ST_MS: begin
                speed_next = acc_reg + prod_reg;
                state_next = ST_ML;
            end
            ST_ML: begin
                lhs_next   = {prod_reg[25:0], 15'b0};
                state_next = ST_MH;
            end
            ST_MH: begin
                rlo_next   = prod_reg[32:0];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                hit_next   = (speed_reg > 36'sd0) && ({7'b0, lhs_reg} <= rhs);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!last_reg) begin
                    collision_next = collision_reg || hit_reg;
                    state_next     = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_brake_next      = collision_reg || hit_reg;
                    collision_next    = 1'b0;
                    scan_started_next = 1'b0;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            angle_start_reg  <= lteb_pkg::ANGLE_START_RST;
            angle_step_reg   <= lteb_pkg::ANGLE_STEP_RST;
            range_limit_reg  <= lteb_pkg::RANGE_LIMIT_RST;
            ttc_thr_reg      <= lteb_pkg::TTC_THRESHOLD_RST;
            angle_phase_reg  <= 16'd0;
            scan_started_reg <= 1'b0;
            collision_reg    <= 1'b0;
            hit_reg          <= 1'b0;
            pass_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            angle_start_reg  <= angle_start_next;
            angle_step_reg   <= angle_step_next;
            range_limit_reg  <= range_limit_next;
            ttc_thr_reg      <= ttc_thr_next;
            angle_phase_reg  <= angle_phase_next;
            scan_started_reg <= scan_started_next;
            collision_reg    <= collision_next;
            hit_reg          <= hit_next;
            pass_reg         <= pass_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_brake_reg <= m_brake_next;
        range_reg   <= range_next;
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        last_reg    <= last_next;
        qangle_reg  <= qangle_next;
        ang_reg     <= ang_next;
        x2_reg      <= x2_next;
        cos_reg     <= cos_next;
        sin_reg     <= sin_next;
        acc_reg     <= acc_next;
        speed_reg   <= speed_next;
        lhs_reg     <= lhs_next;
        rlo_reg     <= rlo_next;
        prod_reg    <= prod_next;
    end

endmodule

// ----- src/lteb_checker.sv -----
// Port-level checker for lidar_ttc_emergency_brake_core, bound to the top level.
// Depends only on the core's port list.
module lteb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_brake
);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transaction");

    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_brake))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transaction");

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind lidar_ttc_emergency_brake_core lteb_checker u_lteb_checker (.*);
